### rtl/art_pkg.sv
// ----------------------------------------------------------------------------
// art_pkg
// Types and codes shared by the address range table core and its tests.
// ----------------------------------------------------------------------------
package art_pkg;

   localparam int ADDR_W   = 48;
   localparam int FLAGS_W  = 32;
   localparam int STATUS_W = 3;
   localparam int INDEX_W  = 4;
   localparam int COUNT_W  = 5;

   localparam logic [1:0] ACT_ADD    = 2'd0;
   localparam logic [1:0] ACT_FIND   = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_OVERLAP   = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_BAD_ARGS  = 3'd4;

   typedef struct packed {
      logic [1:0]         action;
      logic [ADDR_W-1:0]  start_addr;
      logic [ADDR_W-1:0]  end_addr;
      logic [FLAGS_W-1:0] area_flags;
   } art_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  match_index;
      logic [ADDR_W-1:0]   match_start;
      logic [ADDR_W-1:0]   match_end;
      logic [FLAGS_W-1:0]  match_flags;
      logic [COUNT_W-1:0]  range_count;
   } art_rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_APPEND,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_CLEAR,
      S_RESP
   } art_state_type;

endpackage

### rtl/address_range_table_core.sv
// ----------------------------------------------------------------------------
// address_range_table_core
// Table of non-overlapping page-aligned address ranges with add, find and
// remove actions; entries live in one RAM, scanned and compacted in place.
// ----------------------------------------------------------------------------
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   art_req_type (action, addresses, flags)
//   rsp      out        rsp_valid/rsp_stall   art_rsp_type (status, match, count)
//
// Each stored entry is scanned by a RAM read state, then a compare state,
// as the single read port is registered; remove also compacts in place.
// Reset clears the state, the output valid and the fill count, not the RAM;
// slots at or above the count are never read.
// req_stall is high while an action is in flight; one finished beat may wait
// in the output register while the next request is taken.
// ----------------------------------------------------------------------------
module address_range_table_core
   import art_pkg::*;
#(
   parameter int MAX_RANGES       = 16,
   parameter int PAGE_OFFSET_BITS = 12,
   parameter int ADDR_BITS        = 48
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  art_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output art_rsp_type rsp_data
);

   localparam int AW = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
   localparam int EW = 2 * AW + FLAGS_W;
   localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CW = $clog2(MAX_RANGES + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RANGES);
   localparam logic [AW-1:0] OFS_MASK = AW'((64'd1 << PAGE_OFFSET_BITS) - 64'd1);

   art_state_type   state_ff, state_in;
   art_req_type     op_ff, op_in;
   art_rsp_type     res_ff, res_in;
   art_rsp_type     rsp_data_ff, rsp_data_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]   ptr_ff, ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   logic            ram_wr_en, ram_rd_en;
   logic [IW-1:0]   ram_wr_addr, ram_rd_addr;
   logic [EW-1:0]   ram_wr_data, ram_rd_data;

   logic [AW-1:0]   op_start, op_end;
   logic [AW-1:0]   ent_start, ent_end;
   logic [FLAGS_W-1:0] ent_flags;
   logic            args_bad, hit_overlap, hit_find, hit_remove;
   logic [CW:0]     ptr_nxt, ptr_nxt2, count_ext;
   logic [IW+3:0]   idx_wide;
   logic [CW+4:0]   cnt_wide;
   logic [CW-1:0]   count_dec;

   art_ram #(
      .WIDTH(EW),
      .DEPTH(MAX_RANGES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign op_start  = op_ff.start_addr[AW-1:0];
   assign op_end    = op_ff.end_addr[AW-1:0];
   assign ent_start = ram_rd_data[EW-1 -: AW];
   assign ent_end   = ram_rd_data[FLAGS_W+AW-1 -: AW];
   assign ent_flags = ram_rd_data[FLAGS_W-1:0];

   assign args_bad    = (op_start >= op_end) || ((op_start & OFS_MASK) != '0)
                        || ((op_end & OFS_MASK) != '0);
   assign hit_overlap = (op_start < ent_end) && (op_end > ent_start);
   assign hit_find    = (ent_start <= op_start) && (op_start < ent_end);
   assign hit_remove  = (ent_start == op_start);

   assign count_ext = {1'b0, count_ff};
   assign ptr_nxt   = {{(CW + 1 - IW){1'b0}}, ptr_ff} + 1'b1;
   assign ptr_nxt2  = ptr_nxt + 1'b1;
   assign count_dec = count_ff - 1'b1;
   assign idx_wide  = {4'b0, ptr_ff};
   assign cnt_wide  = {5'b0, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      res_ff      <= res_in;
      ptr_ff      <= ptr_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      res_in       = res_ff;
      ptr_in       = ptr_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = ptr_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = ptr_ff;
      ram_wr_data  = ram_rd_data;

      // drop the held beat once it is taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_data;
               res_in   = '0;
               ptr_in   = '0;
               state_in = S_START;
            end
         end
         S_START: begin
            unique case (op_ff.action)
               ACT_ADD: begin
                  if (args_bad) begin
                     res_in.status = STAT_BAD_ARGS;
                     state_in      = S_RESP;
                  end else if (count_ff >= MAX_CNT) begin
                     res_in.status = STAT_FULL;
                     state_in      = S_RESP;
                  end else if (count_ff == '0) begin
                     state_in = S_APPEND;
                  end else begin
                     state_in = S_SCAN_RD;
                  end
               end
               ACT_FIND, ACT_REMOVE: begin
                  if (count_ff == '0) begin
                     res_in.status = STAT_NOT_FOUND;
                     state_in      = S_RESP;
                  end else begin
                     state_in = S_SCAN_RD;
                  end
               end
               default: begin
                  res_in.status = STAT_BAD_ARGS;
                  state_in      = S_RESP;
               end
            endcase
         end
         S_SCAN_RD: begin
            ram_rd_en = 1'b1;
            state_in  = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (op_ff.action == ACT_ADD && hit_overlap) begin
               res_in.status = STAT_OVERLAP;
               state_in      = S_RESP;
            end else if (op_ff.action == ACT_FIND && hit_find) begin
               res_in.status      = STAT_OK;
               res_in.match_index = idx_wide[INDEX_W-1:0];
               res_in.match_start = ADDR_W'(ent_start);
               res_in.match_end   = ADDR_W'(ent_end);
               res_in.match_flags = ent_flags;
               state_in           = S_RESP;
            end else if (op_ff.action == ACT_REMOVE && hit_remove) begin
               res_in.status      = STAT_OK;
               res_in.match_index = idx_wide[INDEX_W-1:0];
               state_in           = (ptr_nxt < count_ext) ? S_SHIFT_RD : S_CLEAR;
            end else if (ptr_nxt < count_ext) begin
               ptr_in   = ptr_nxt[IW-1:0];
               state_in = S_SCAN_RD;
            end else if (op_ff.action == ACT_ADD) begin
               state_in = S_APPEND;
            end else begin
               res_in.status = STAT_NOT_FOUND;
               state_in      = S_RESP;
            end
         end
         S_APPEND: begin
            ram_wr_en     = 1'b1;
            ram_wr_addr   = count_ff[IW-1:0];
            ram_wr_data   = {op_start, op_end, op_ff.area_flags};
            count_in      = count_ff + 1'b1;
            res_in.status = STAT_OK;
            state_in      = S_RESP;
         end
         S_SHIFT_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = ptr_nxt[IW-1:0];
            state_in    = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            // move the entry above down into this slot
            ram_wr_en = 1'b1;
            ptr_in    = ptr_nxt[IW-1:0];
            state_in  = (ptr_nxt2 < count_ext) ? S_SHIFT_RD : S_CLEAR;
         end
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = count_dec[IW-1:0];
            ram_wr_data = '0;
            count_in    = count_dec;
            state_in    = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in             = res_ff;
               rsp_data_in.range_count = cnt_wide[COUNT_W-1:0];
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("range count above table depth");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_START))
      else $error("accepted request did not start an action");

   a_count_change: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         ($past(state_ff) == S_APPEND || $past(state_ff) == S_CLEAR))
      else $error("range count changed outside append or clear");

   a_resp_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && (!rsp_valid_ff || !rsp_stall)) |=>
         (rsp_valid_ff && rsp_data_ff.range_count == cnt_wide[COUNT_W-1:0]))
      else $error("finished action did not reach the output register");

endmodule

### rtl/art_ram.sv
// ----------------------------------------------------------------------------
// art_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module art_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for address_range_table_core. A generator queues add,
// find and remove beats (directed corner cases, then random traffic aimed at
// one low and one high address window so ranges collide, hit and vanish).
// Each accepted beat runs through a shadow range table to build the expected
// reply, and the monitor compares every reply field by field, in order.
// ----------------------------------------------------------------------------
module tb_top
   import art_pkg::*;
();

   localparam int MAX_AREAS    = 16;
   localparam int PAGE_BITS    = 12;
   localparam int RANDOM_OPS   = 2000;
   localparam int WINDOW_PAGES = 96;
   localparam int DRAIN_CYCLES = 64;
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   // 97 pages below the top of the address space
   localparam logic [ADDR_W-1:0] HIGH_WINDOW = 48'hFFFF_FFF9_F000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   art_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   art_rsp_type rsp_data;

   // shadow copy of the range table
   logic [ADDR_W-1:0]  area_base [MAX_AREAS];
   logic [ADDR_W-1:0]  area_limit[MAX_AREAS];
   logic [FLAGS_W-1:0] area_attr [MAX_AREAS];
   int unsigned        area_count;

   art_req_type op_backlog[$];
   art_rsp_type reply_due[$];
   art_rsp_type reply_want;
   int unsigned ops_queued;
   int unsigned ops_accepted;
   int unsigned mismatch_count;
   int unsigned hold_left;
   bit          hold_done;

   address_range_table_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Apply one action to the shadow table and return the reply it must give.
   function automatic art_rsp_type table_apply(input art_req_type op);
      art_rsp_type       reply;
      logic [ADDR_W-1:0] lo;
      logic [ADDR_W-1:0] hi;
      bit                hit;
      int unsigned       slot;
      reply = '0;
      reply.status = STAT_BAD_ARGS;
      lo = op.start_addr;
      hi = op.end_addr;
      hit = 1'b0;
      slot = 0;
      case (op.action)
         ACT_ADD: begin
            if (lo >= hi || lo[PAGE_BITS-1:0] != '0 || hi[PAGE_BITS-1:0] != '0) begin
               reply.status = STAT_BAD_ARGS;
            end else if (area_count >= MAX_AREAS) begin
               reply.status = STAT_FULL;
            end else begin
               for (int i = 0; i < area_count; i++)
                  if (lo < area_limit[i] && hi > area_base[i]) hit = 1'b1;
               if (hit) begin
                  reply.status = STAT_OVERLAP;
               end else begin
                  area_base[area_count]  = lo;
                  area_limit[area_count] = hi;
                  area_attr[area_count]  = op.area_flags;
                  area_count++;
                  reply.status = STAT_OK;
               end
            end
         end
         ACT_FIND: begin
            for (int i = 0; i < area_count; i++) begin
               if (!hit && area_base[i] <= lo && lo < area_limit[i]) begin
                  hit = 1'b1;
                  slot = i;
               end
            end
            if (hit) begin
               reply.status      = STAT_OK;
               reply.match_index = INDEX_W'(slot);
               reply.match_start = area_base[slot];
               reply.match_end   = area_limit[slot];
               reply.match_flags = area_attr[slot];
            end else begin
               reply.status = STAT_NOT_FOUND;
            end
         end
         ACT_REMOVE: begin
            for (int i = 0; i < area_count; i++) begin
               if (!hit && area_base[i] == lo) begin
                  hit = 1'b1;
                  slot = i;
               end
            end
            if (hit) begin
               // close the gap, then wipe the slot that fell free
               for (int i = slot; i + 1 < area_count; i++) begin
                  area_base[i]  = area_base[i+1];
                  area_limit[i] = area_limit[i+1];
                  area_attr[i]  = area_attr[i+1];
               end
               area_count--;
               area_base[area_count]  = '0;
               area_limit[area_count] = '0;
               area_attr[area_count]  = '0;
               reply.status      = STAT_OK;
               reply.match_index = INDEX_W'(slot);
            end else begin
               reply.status = STAT_NOT_FOUND;
            end
         end
         default: reply.status = STAT_BAD_ARGS;
      endcase
      reply.range_count = COUNT_W'(area_count);
      return reply;
   endfunction

   // sender idles 33/83/0 percent over the three thirds, receiver 83/33/0
   function automatic int unsigned idle_pct(input bit receiver);
      if (ops_accepted < RANDOM_OPS / 3) return receiver ? 83 : 33;
      if (ops_accepted < 2 * RANDOM_OPS / 3) return receiver ? 33 : 83;
      return 0;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s expected %0h actual %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic queue_op(input logic [1:0] action, input logic [ADDR_W-1:0] lo,
                           input logic [ADDR_W-1:0] hi, input logic [FLAGS_W-1:0] attr);
      art_req_type op;
      op.action     = action;
      op.start_addr = lo;
      op.end_addr   = hi;
      op.area_flags = attr;
      op_backlog.push_back(op);
      ops_queued++;
   endtask

   // driver: hold the beat while stalled, pick the next one otherwise
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            reply_due.push_back(table_apply(req_data));
            ops_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (op_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
               req_valid <= 1'b1;
               req_data  <= op_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // hold off the receiver once for a long stretch late in the run
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && ops_accepted >= 2 * RANDOM_OPS / 3 + 200) begin
         hold_left <= 400;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor: check replies and drive stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (reply_due.size() == 0) begin
               $error("reply beat with nothing expected: %p", rsp_data);
               mismatch_count++;
            end else begin
               reply_want = reply_due.pop_front();
               check_field("status", reply_want.status, rsp_data.status);
               check_field("match_index", reply_want.match_index, rsp_data.match_index);
               check_field("match_start", reply_want.match_start, rsp_data.match_start);
               check_field("match_end", reply_want.match_end, rsp_data.match_end);
               check_field("match_flags", reply_want.match_flags, rsp_data.match_flags);
               check_field("range_count", reply_want.range_count, rsp_data.range_count);
            end
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < idle_pct(1'b1));
         end
      end
   end

   initial begin
      #20_000_000;
      $display("address_range_table_core: mismatch");
      $finish;
   end

   initial begin
      art_req_type       op;
      int unsigned       roll;
      int unsigned       pick;
      int unsigned       add_w;
      int unsigned       rm_w;
      bit                fill_bias;
      bit                upper;
      logic [ADDR_W-1:0] base;
      logic [63:0]       span;
      fill_bias = 1'b0;
      area_count = 0;
      for (int i = 0; i < MAX_AREAS; i++) begin
         area_base[i]  = '0;
         area_limit[i] = '0;
         area_attr[i]  = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty table, argument checks, unused code
      queue_op(ACT_FIND, 48'h5000, '0, '0);
      queue_op(ACT_REMOVE, '0, '0, '0);
      queue_op(ACT_ADD, 48'h3000, 48'h3000, 32'h1);
      queue_op(ACT_ADD, 48'h1001, 48'h2000, 32'h2);
      queue_op(ACT_ADD, 48'h1000, 48'h2FFF, 32'h3);
      queue_op(ACT_UNUSED, '1, '1, '1);
      // lowest and highest addable pages, overlap, inclusive start and exclusive end
      queue_op(ACT_ADD, '0, 48'h1000, '0);
      queue_op(ACT_ADD, 48'hFFFF_FFFF_E000, 48'hFFFF_FFFF_F000, '1);
      queue_op(ACT_ADD, '0, 48'h2000, 32'h5A5A_A5A5);
      queue_op(ACT_FIND, 48'hFFF, '0, '0);
      queue_op(ACT_FIND, 48'h1000, '0, '0);
      queue_op(ACT_FIND, 48'hFFFF_FFFF_EFFF, '0, '0);
      // fill every slot, then one more
      for (int k = 0; k < MAX_AREAS - 2; k++)
         queue_op(ACT_ADD, 48'h10000 + k * 48'h2000, 48'h11000 + k * 48'h2000, $urandom);
      queue_op(ACT_ADD, 48'h80000, 48'h81000, 32'hFF);
      // remove from the middle, look up the shifted entry, remove slot one
      queue_op(ACT_REMOVE, 48'h16000, '0, '0);
      queue_op(ACT_FIND, 48'h18800, '0, '0);
      queue_op(ACT_REMOVE, 48'hFFFF_FFFF_E000, '0, '0);

      for (int n = 0; n < RANDOM_OPS; n++) begin
         // keep the backlog short so the shadow table stays close to the block
         while (op_backlog.size() >= 2) @(posedge clock);
         if (n % 150 == 0) fill_bias = ~fill_bias;
         add_w = fill_bias ? 45 : 25;
         rm_w  = fill_bias ? 10 : 30;
         roll  = $urandom_range(0, 99);
         upper = ($urandom_range(0, 4) == 0);
         base  = (upper ? HIGH_WINDOW : '0)
               + (ADDR_W'($urandom_range(0, WINDOW_PAGES - 5)) << PAGE_BITS);
         op.area_flags = $urandom;
         op.end_addr   = ADDR_W'({$urandom, $urandom});
         if (roll < add_w) begin
            op.action     = ACT_ADD;
            op.start_addr = base;
            op.end_addr   = base + (ADDR_W'($urandom_range(1, 4)) << PAGE_BITS);
         end else if (roll < add_w + 30) begin
            op.action = ACT_FIND;
            if (area_count != 0 && $urandom_range(0, 3) != 0) begin
               pick = $urandom_range(0, area_count - 1);
               span = 64'(area_limit[pick] - area_base[pick]);
               op.start_addr = area_base[pick] + ADDR_W'({$urandom, $urandom} % span);
            end else begin
               op.start_addr = base + ADDR_W'($urandom_range(0, 4095));
            end
         end else if (roll < add_w + 30 + rm_w) begin
            op.action = ACT_REMOVE;
            if (area_count != 0 && $urandom_range(0, 3) != 0) begin
               pick = $urandom_range(0, area_count - 1);
               op.start_addr = area_base[pick];
            end else begin
               op.start_addr = base + ($urandom_range(0, 1) ? 48'h1000 : 48'h0);
            end
         end else begin
            case ($urandom_range(0, 3))
               0: begin
                  op.action     = 2'($urandom);
                  op.start_addr = ADDR_W'({$urandom, $urandom});
               end
               1: begin
                  op.action = ACT_ADD;
                  if ($urandom_range(0, 1)) begin
                     op.start_addr = base + ADDR_W'($urandom_range(1, 4095));
                     op.end_addr   = base + 48'h2000;
                  end else begin
                     op.start_addr = base;
                     op.end_addr   = base + 48'h1000 + ADDR_W'($urandom_range(1, 4095));
                  end
               end
               2: begin
                  op.action     = ACT_ADD;
                  op.start_addr = base + 48'h1000;
                  op.end_addr   = $urandom_range(0, 1) ? base : base + 48'h1000;
               end
               default: begin
                  op.action     = ACT_UNUSED;
                  op.start_addr = base;
                  op.end_addr   = base + 48'h1000;
               end
            endcase
         end
         queue_op(op.action, op.start_addr, op.end_addr, op.area_flags);
      end

      while (ops_accepted != ops_queued) @(posedge clock);
      while (reply_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("address_range_table_core: match");
      else
         $display("address_range_table_core: mismatch");
      $finish;
   end

endmodule

### sim.f
rtl/art_pkg.sv
rtl/art_ram.sv
rtl/address_range_table_core.sv
verif/tb_top.sv
